### hdl/epc_pkg.sv
// Shared constants and types for the Ethernet packet classifier.
// Used by epc_capture, epc_classify and ethernet_packet_classifier.
// No dependencies.
package epc_pkg;

    // Byte counter width and its saturation value.
    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // EtherType codes.
    localparam logic [15:0] ET_IPV4 = 16'h0800;
    localparam logic [15:0] ET_IPV6 = 16'h86DD;
    localparam logic [15:0] ET_ARP  = 16'h0806;

    // Fixed header offsets and lengths in bytes.
    localparam int POS_ET_HI      = 12;
    localparam int POS_ET_LO      = 13;
    localparam int POS_V4_IHL     = 14;
    localparam int POS_V4_LEN_HI  = 16;
    localparam int POS_V4_LEN_LO  = 17;
    localparam int POS_V4_PROTO   = 23;
    localparam int POS_V6_NEXT    = 20;
    localparam int MAC_LEN        = 14;
    localparam int IPV6_LEN       = 40;
    localparam logic [3:0] MIN_WORDS = 4'd5;

    // IP protocol numbers.
    localparam logic [7:0] PROTO_ICMP  = 8'd1;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] PROTO_ICMP6 = 8'd58;

    // TLS record header limits.
    localparam logic [7:0]  TLS_TYPE_LO = 8'd20;
    localparam logic [7:0]  TLS_TYPE_HI = 8'd23;
    localparam logic [15:0] TLS_VER_LO  = 16'h0301;
    localparam logic [15:0] TLS_VER_HI  = 16'h0304;

    // Packet class codes.
    localparam logic [2:0] CLS_OTHER    = 3'd0;
    localparam logic [2:0] CLS_ICMP     = 3'd1;
    localparam logic [2:0] CLS_TCP      = 3'd2;
    localparam logic [2:0] CLS_UDP      = 3'd3;
    localparam logic [2:0] CLS_DNS      = 3'd4;
    localparam logic [2:0] CLS_TLS      = 3'd5;
    localparam logic [2:0] CLS_TLS_CONT = 3'd6;

    // Configuration register indexes and reset values.
    localparam logic CFG_HTTPS_PORT = 1'b0;
    localparam logic CFG_DNS_PORT   = 1'b1;
    localparam logic [15:0] HTTPS_PORT_RESET = 16'd443;
    localparam logic [15:0] DNS_PORT_RESET   = 16'd53;

    // Header fields captured from one frame, plus the byte position.
    typedef struct packed {
        logic [15:0]           ether_type;
        logic [3:0]            ip_header_words;
        logic [15:0]           ip_total_length;
        logic [7:0]            next_protocol;
        logic [15:0]           port_src;
        logic [15:0]           port_dst;
        logic [3:0]            tcp_offset_words;
        logic [5:0]            flag_bits;
        logic [31:0]           seq_value;
        logic [31:0]           ack_value;
        logic [15:0]           window_value;
        logic [15:0]           udp_length;
        logic [7:0]            tls_content_type;
        logic [15:0]           tls_version;
        logic [7:0]            icmp_type_seen;
        logic [7:0]            icmp_code_seen;
        logic [COUNT_BITS-1:0] byte_position;
    } t_frame_info;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] https_port;
        logic [15:0] dns_port;
    } t_cfg;

    // One classification result.
    typedef struct packed {
        logic [2:0]  packet_class;
        logic        is_ipv6;
        logic [15:0] frame_length;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [5:0]  tcp_flags;
        logic [31:0] tcp_seq;
        logic [31:0] tcp_ack;
        logic [15:0] tcp_window;
        logic [15:0] payload_length;
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
    } t_result;

endpackage

### hdl/epc_capture.sv
// Byte counter and header field capture for the packet classifier.
// Depends on epc_pkg.
module epc_capture (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beat,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output epc_pkg::t_frame_info o_info,
    output logic               o_known
);
    import epc_pkg::*;

    t_frame_info r_st;
    t_frame_info n_st;
    logic        v4;
    logic        v6;
    logic [3:0]  ihl_eff;
    logic [3:0]  toff_eff;
    logic [7:0]  l4_start;
    logic [7:0]  tls_start;
    logic        in_l4;
    logic [COUNT_BITS-1:0] pos;
    logic [COUNT_BITS-1:0] d;

    // Next header state after the current byte is taken in.
    always_comb begin
        pos  = r_st.byte_position;
        n_st = r_st;

        if (pos == COUNT_BITS'(POS_ET_HI)) begin
            n_st.ether_type[15:8] = i_byte;
        end else if (pos == COUNT_BITS'(POS_ET_LO)) begin
            n_st.ether_type[7:0] = i_byte;
        end

        v4 = (n_st.ether_type == ET_IPV4);
        v6 = (n_st.ether_type == ET_IPV6);

        // Network layer fields.
        if (v4) begin
            if (pos == COUNT_BITS'(POS_V4_IHL)) begin
                n_st.ip_header_words = i_byte[3:0];
            end else if (pos == COUNT_BITS'(POS_V4_LEN_HI)) begin
                n_st.ip_total_length[15:8] = i_byte;
            end else if (pos == COUNT_BITS'(POS_V4_LEN_LO)) begin
                n_st.ip_total_length[7:0] = i_byte;
            end else if (pos == COUNT_BITS'(POS_V4_PROTO)) begin
                n_st.next_protocol = i_byte;
            end
        end else if (v6) begin
            if (pos == COUNT_BITS'(POS_V6_NEXT)) begin
                n_st.next_protocol = i_byte;
            end
        end

        // Start of the transport header.
        ihl_eff  = (n_st.ip_header_words < MIN_WORDS) ? MIN_WORDS : n_st.ip_header_words;
        l4_start = v6 ? 8'(MAC_LEN + IPV6_LEN) : 8'(MAC_LEN) + {2'b00, ihl_eff, 2'b00};
        in_l4    = (v4 || v6) && (pos >= COUNT_BITS'(l4_start));
        d        = pos - COUNT_BITS'(l4_start);

        // Transport header fields.
        if (in_l4) begin
            if (d == COUNT_BITS'(0)) begin
                n_st.port_src[15:8] = i_byte;
                n_st.icmp_type_seen = i_byte;
            end else if (d == COUNT_BITS'(1)) begin
                n_st.port_src[7:0]  = i_byte;
                n_st.icmp_code_seen = i_byte;
            end else if (d == COUNT_BITS'(2)) begin
                n_st.port_dst[15:8] = i_byte;
            end else if (d == COUNT_BITS'(3)) begin
                n_st.port_dst[7:0] = i_byte;
            end

            if (d == COUNT_BITS'(4)) begin
                n_st.udp_length[15:8] = i_byte;
            end else if (d == COUNT_BITS'(5)) begin
                n_st.udp_length[7:0] = i_byte;
            end

            if (d >= COUNT_BITS'(4) && d <= COUNT_BITS'(7)) begin
                n_st.seq_value = {r_st.seq_value[23:0], i_byte};
            end else if (d >= COUNT_BITS'(8) && d <= COUNT_BITS'(11)) begin
                n_st.ack_value = {r_st.ack_value[23:0], i_byte};
            end else if (d == COUNT_BITS'(12)) begin
                n_st.tcp_offset_words = i_byte[7:4];
            end else if (d == COUNT_BITS'(13)) begin
                n_st.flag_bits = i_byte[5:0];
            end else if (d == COUNT_BITS'(14)) begin
                n_st.window_value[15:8] = i_byte;
            end else if (d == COUNT_BITS'(15)) begin
                n_st.window_value[7:0] = i_byte;
            end
        end

        // TLS record header right after the TCP header.
        toff_eff  = (n_st.tcp_offset_words < MIN_WORDS) ? MIN_WORDS : n_st.tcp_offset_words;
        tls_start = l4_start + {2'b00, toff_eff, 2'b00};
        if (in_l4) begin
            if (pos == COUNT_BITS'(tls_start)) begin
                n_st.tls_content_type = i_byte;
            end else if (pos == COUNT_BITS'(tls_start) + COUNT_BITS'(1)) begin
                n_st.tls_version[15:8] = i_byte;
            end else if (pos == COUNT_BITS'(tls_start) + COUNT_BITS'(2)) begin
                n_st.tls_version[7:0] = i_byte;
            end
        end

        // Saturating byte counter.
        n_st.byte_position = (pos == COUNT_MAX) ? pos : pos + COUNT_BITS'(1);
    end

    assign o_info  = n_st;
    assign o_known = v4 || v6 || (n_st.ether_type == ET_ARP);

    // Frame state clears after each final byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_beat) begin
            if (i_last) begin
                r_st <= '0;
            end else begin
                r_st <= n_st;
            end
        end
    end

endmodule

### hdl/epc_classify.sv
// Frame snapshot register, classification logic and result register.
// Depends on epc_pkg.
module epc_classify (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  epc_pkg::t_frame_info i_info,
    input  epc_pkg::t_cfg        i_cfg,
    input  logic                 i_out_stall,
    output logic                 o_ready,
    output logic                 o_valid,
    output epc_pkg::t_result     o_result
);
    import epc_pkg::*;

    logic        r_snap_valid;
    t_frame_info r_snap;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_res;
    logic        out_free;
    logic        snap_go;
    logic        v4;
    logic        v6;
    logic [7:0]  icmp_id;
    logic [3:0]  ihl_eff;
    logic [3:0]  toff_eff;
    logic [6:0]  hdr_len;
    logic        tls_rec;

    // Pipeline flow control.
    assign out_free = !r_out_valid || !i_out_stall;
    assign snap_go  = r_snap_valid && out_free;
    assign o_ready  = !r_snap_valid || out_free;

    // Classification of the captured header fields.
    always_comb begin
        v4       = (r_snap.ether_type == ET_IPV4);
        v6       = (r_snap.ether_type == ET_IPV6);
        icmp_id  = v4 ? PROTO_ICMP : PROTO_ICMP6;
        ihl_eff  = (r_snap.ip_header_words < MIN_WORDS) ? MIN_WORDS : r_snap.ip_header_words;
        toff_eff = (r_snap.tcp_offset_words < MIN_WORDS) ? MIN_WORDS : r_snap.tcp_offset_words;
        hdr_len  = {1'b0, ihl_eff, 2'b00} + {1'b0, toff_eff, 2'b00};
        tls_rec  = (r_snap.tls_content_type >= TLS_TYPE_LO)
                && (r_snap.tls_content_type <= TLS_TYPE_HI)
                && (r_snap.tls_version >= TLS_VER_LO)
                && (r_snap.tls_version <= TLS_VER_HI);

        n_res              = '0;
        n_res.packet_class = CLS_OTHER;
        n_res.is_ipv6      = v6;
        n_res.frame_length = 16'(r_snap.byte_position);

        if (v4 || v6) begin
            if (r_snap.next_protocol == icmp_id) begin
                n_res.packet_class = CLS_ICMP;
                n_res.icmp_type    = r_snap.icmp_type_seen;
                n_res.icmp_code    = r_snap.icmp_code_seen;
            end else if (r_snap.next_protocol == PROTO_TCP) begin
                n_res.packet_class = CLS_TCP;
                n_res.source_port  = r_snap.port_src;
                n_res.dest_port    = r_snap.port_dst;
                n_res.tcp_flags    = r_snap.flag_bits;
                n_res.tcp_seq      = r_snap.seq_value;
                n_res.tcp_ack      = r_snap.ack_value;
                n_res.tcp_window   = r_snap.window_value;
                if (r_snap.port_src == i_cfg.https_port
                        || r_snap.port_dst == i_cfg.https_port) begin
                    n_res.packet_class = tls_rec ? CLS_TLS : CLS_TLS_CONT;
                end
                if (v4 && (r_snap.ip_total_length > {9'd0, hdr_len})) begin
                    n_res.payload_length = r_snap.ip_total_length - {9'd0, hdr_len};
                end
            end else if (r_snap.next_protocol == PROTO_UDP) begin
                n_res.packet_class = (r_snap.port_src == i_cfg.dns_port
                        || r_snap.port_dst == i_cfg.dns_port) ? CLS_DNS : CLS_UDP;
                n_res.source_port    = r_snap.port_src;
                n_res.dest_port      = r_snap.port_dst;
                n_res.payload_length = r_snap.udp_length;
            end
        end
    end

    // Snapshot stage: holds the fields of one finished frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (i_load) begin
            r_snap_valid <= 1'b1;
        end else if (snap_go) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_snap <= i_info;
        end
    end

    // Result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (snap_go) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_go) begin
            r_out <= n_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // A new frame is never loaded over a snapshot that cannot move on.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_ready)
        else $error("snapshot overwritten while occupied");

    // A snapshot blocked by a stalled result stays in place.
    a_snap_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap_valid && !out_free) |=> r_snap_valid)
        else $error("blocked snapshot was dropped");

    // Every delivered class code is a defined class.
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.packet_class <= CLS_TLS_CONT))
        else $error("undefined packet class");

    // TCP flags, a TCP-only field, stay zero for non-TCP classes.
    a_tcp_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.tcp_flags != 6'd0) |->
        (r_out.packet_class == CLS_TCP || r_out.packet_class == CLS_TLS
            || r_out.packet_class == CLS_TLS_CONT))
        else $error("TCP flags reported on a non-TCP class");

endmodule

### hdl/ethernet_packet_classifier.sv
// Ethernet packet classifier top level: configuration registers and
// the byte capture and classification stages.
// Depends on epc_pkg, epc_capture and epc_classify.
//
// Usage: frame bytes enter on the input channel (i_in_valid, o_in_stall,
// i_frame_byte, i_last_byte), one beat per byte starting at the
// destination MAC, with i_last_byte set on the final byte. One byte is
// taken per clock cycle while o_in_stall is low; each byte only updates
// the counter and captured fields, so the sustained rate is one beat per
// cycle unless o_in_stall rises. On the final byte of an ARP, IPv4 or
// IPv6 frame one result beat leaves on the output channel (o_out_valid,
// i_out_stall) via the frame snapshot register, then the result register.
// Frames with any other EtherType produce no result. When the receiver
// stalls, the result register holds; the snapshot register absorbs one
// more finished frame, and only when both are full does o_in_stall rise,
// which holds off further bytes. Reset (synchronous, active low) clears
// the frame state, empties both stages and sets the HTTPS port to 443 and
// the DNS port to 53. Ports are written through i_cfg_we, i_cfg_index and
// i_cfg_data by the user only while idle; the block does not enforce it.
module ethernet_packet_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_packet_class,
    output logic        o_is_ipv6,
    output logic [15:0] o_frame_length,
    output logic [15:0] o_source_port,
    output logic [15:0] o_dest_port,
    output logic [5:0]  o_tcp_flags,
    output logic [31:0] o_tcp_seq,
    output logic [31:0] o_tcp_ack,
    output logic [15:0] o_tcp_window,
    output logic [15:0] o_payload_length,
    output logic [7:0]  o_icmp_type,
    output logic [7:0]  o_icmp_code,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import epc_pkg::*;

    t_cfg        r_cfg;
    t_frame_info info;
    t_result     result;
    logic        known;
    logic        ready;
    logic        beat;
    logic        load;

    // Input handshake.
    assign o_in_stall = !ready;
    assign beat       = i_in_valid && !o_in_stall;
    assign load       = beat && i_last_byte && known;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.https_port <= HTTPS_PORT_RESET;
            r_cfg.dns_port   <= DNS_PORT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HTTPS_PORT: r_cfg.https_port <= i_cfg_data;
                CFG_DNS_PORT:   r_cfg.dns_port   <= i_cfg_data;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    epc_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (beat),
        .i_byte  (i_frame_byte),
        .i_last  (i_last_byte),
        .o_info  (info),
        .o_known (known)
    );

    epc_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_info      (info),
        .i_cfg       (r_cfg),
        .i_out_stall (i_out_stall),
        .o_ready     (ready),
        .o_valid     (o_out_valid),
        .o_result    (result)
    );

    // Result fields onto their ports.
    assign o_packet_class   = result.packet_class;
    assign o_is_ipv6        = result.is_ipv6;
    assign o_frame_length   = result.frame_length;
    assign o_source_port    = result.source_port;
    assign o_dest_port      = result.dest_port;
    assign o_tcp_flags      = result.tcp_flags;
    assign o_tcp_seq        = result.tcp_seq;
    assign o_tcp_ack        = result.tcp_ack;
    assign o_tcp_window     = result.tcp_window;
    assign o_payload_length = result.payload_length;
    assign o_icmp_type      = result.icmp_type;
    assign o_icmp_code      = result.icmp_code;

endmodule
